// ===== sv/unsorted_priority_queue_assert.svh =====
// Assertion macros shared by the queue RTL.
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef UNSORTED_PRIORITY_QUEUE_ASSERT_SVH
`define UNSORTED_PRIORITY_QUEUE_ASSERT_SVH

// General property, clocked on clk, off during reset.
`define UPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define UPQ_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== sv/upq_pkg.sv =====
// Shared types for the unsorted priority queue: op and status codes,
// sequencer states and the stored entry layout. No dependencies.
package upq_pkg;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_POP_MIN = 2'd1,
		OP_POP_MAX = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_MOVE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} entry_t;

endpackage

// ===== sv/upq_store.sv =====
// Entry storage: one write port, one read port with registered data.
// Depends on upq_pkg (entry_t).
module upq_store #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  upq_pkg::entry_t wr_entry,
	input  logic [AW-1:0]   rd_addr,
	output upq_pkg::entry_t rd_entry
);
	import upq_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	assign rd_entry = rd_q;

endmodule

// ===== sv/upq_scan.sv =====
// Shared priority comparator: keeps the best entry seen in a scan and
// captures the last held entry. Depends on upq_pkg (entry_t).
module upq_scan #(
	parameter int AW = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            want_high,
	input  logic            smp_vld,
	input  logic [AW-1:0]   smp_idx,
	input  upq_pkg::entry_t smp_entry,
	input  logic [AW-1:0]   last_idx,
	output logic [AW-1:0]   best_idx,
	output upq_pkg::entry_t best_entry,
	output upq_pkg::entry_t last_entry
);
	import upq_pkg::*;

	logic          have_q;
	logic [AW-1:0] best_idx_q;
	entry_t        best_q;
	entry_t        last_q;
	logic          take;

	// strict compare: on ties the earlier index stays
	always_comb begin
		if (!have_q) begin
			take = 1'b1;
		end else if (want_high) begin
			take = smp_entry.prio > best_q.prio;
		end else begin
			take = smp_entry.prio < best_q.prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (start) begin
			have_q <= 1'b0;
		end else if (smp_vld) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (smp_vld && take) begin
			best_idx_q <= smp_idx;
			best_q     <= smp_entry;
		end
		if (smp_vld && (smp_idx == last_idx)) begin
			last_q <= smp_entry;
		end
	end

	assign best_idx   = best_idx_q;
	assign best_entry = best_q;
	assign last_entry = last_q;

endmodule

// ===== sv/unsorted_priority_queue.sv =====
// Top level of the unsorted-table double-ended priority queue.
// Depends on upq_pkg, upq_store, upq_scan and unsorted_priority_queue_assert.svh.
//
// channel  handshake            payload
// req      req_valid/req_ready  op, item_value, item_priority
// rsp      rsp_valid/rsp_ready  removed_value, status, occupancy
//
// Insert, op 3 and removal on an empty queue: DECODE, then EMIT loads the result register.
// Removal: the scan issues one read per held entry through the single memory read port
// and one comparator, then MOVE writes the last entry into the freed slot before EMIT.
// Reset clears the count, sequencer and output register; entry storage needs none.
// req_ready is high only while idle; a stalled result holds the sequencer in EMIT.
module unsorted_priority_queue #(
	parameter int DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         op,
	input  logic signed [31:0] item_value,
	input  logic signed [15:0] item_priority,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic signed [31:0] removed_value,
	output logic [1:0]         status,
	output logic [7:0]         occupancy
);
	import upq_pkg::*;

	`include "unsorted_priority_queue_assert.svh"

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [1:0]  op_q;
	entry_t      item_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;     // next scan read address
	logic          smp_vld_s1;
	logic [AW-1:0] smp_idx_s1;

	status_t            res_status_q;
	logic signed [31:0] res_value_q;

	logic               rsp_valid_q;
	logic signed [31:0] rsp_value_q;
	status_t            rsp_status_q;
	logic [7:0]         rsp_occ_q;

	// sequencer outputs
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_entry;
	logic          scan_start;
	logic          issue;
	logic          emit;

	entry_t        rd_entry;
	logic [AW-1:0] best_idx;
	entry_t        best_entry;
	entry_t        last_entry;
	logic [AW-1:0] last_idx;
	logic          full;
	logic          is_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign is_pop   = (op_q == OP_POP_MIN) || (op_q == OP_POP_MAX);
	assign last_idx = AW'(count_q - CW'(1));

	// entry storage
	upq_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_entry(wr_entry),
		.rd_addr (ptr_q[AW-1:0]),
		.rd_entry(rd_entry)
	);

	// shared comparator, fed one entry per cycle during the scan
	upq_scan #(
		.AW(AW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.want_high (op_q == OP_POP_MAX),
		.smp_vld   (smp_vld_s1),
		.smp_idx   (smp_idx_s1),
		.smp_entry (rd_entry),
		.last_idx  (last_idx),
		.best_idx  (best_idx),
		.best_entry(best_entry),
		.last_entry(last_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		wr_en      = 1'b0;
		wr_addr    = count_q[AW-1:0];
		wr_entry   = item_q;
		scan_start = 1'b0;
		issue      = 1'b0;
		emit       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (op_q == OP_INSERT) begin
					wr_en   = !full;   // append at the end
					state_d = ST_EMIT;
				end else if (is_pop && (count_q != '0)) begin
					scan_start = 1'b1;
					state_d    = ST_SCAN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SCAN: begin
				issue = (ptr_q != count_q);
				// done once every read is issued and the last one compared
				if (!issue && !smp_vld_s1) begin
					state_d = ST_MOVE;
				end
			end
			ST_MOVE: begin
				// last entry fills the freed slot (harmless when they coincide)
				wr_en    = 1'b1;
				wr_addr  = best_idx;
				wr_entry = last_entry;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			smp_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DECODE) && (op_q == OP_INSERT) && !full) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == ST_MOVE) begin
				count_q <= count_q - CW'(1);
			end
			if (scan_start) begin
				ptr_q <= '0;
			end else if (issue) begin
				ptr_q <= ptr_q + CW'(1);
			end
			smp_vld_s1 <= issue;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req_valid) begin
			op_q         <= op;
			item_q.value <= item_value;
			item_q.prio  <= item_priority;
		end
		smp_idx_s1 <= ptr_q[AW-1:0];
		if (state_q == ST_DECODE) begin
			res_value_q <= '0;
			if ((op_q == OP_INSERT) && full) begin
				res_status_q <= STAT_FULL;
			end else if (is_pop && (count_q == '0)) begin
				res_status_q <= STAT_EMPTY;
			end else begin
				res_status_q <= STAT_OK;
			end
		end else if (state_q == ST_MOVE) begin
			res_value_q  <= best_entry.value;
			res_status_q <= STAT_OK;
		end
		if (emit) begin
			rsp_value_q  <= res_value_q;
			rsp_status_q <= res_status_q;
			rsp_occ_q    <= 8'(count_q);
		end
	end

	assign req_ready     = (state_q == ST_IDLE);
	assign rsp_valid     = rsp_valid_q;
	assign removed_value = rsp_value_q;
	assign status        = rsp_status_q;
	assign occupancy     = rsp_occ_q;

	`UPQ_NEVER(a_count_bound, count_q > CW'(DEPTH), "entry count above depth")
	`UPQ_NEVER(a_ptr_bound, (state_q == ST_SCAN) && (ptr_q > count_q), "scan pointer past count")
	`UPQ_NEVER(a_scan_nonempty, (state_q == ST_SCAN) && (count_q == '0), "scan on empty queue")
	`UPQ_ASSERT(a_move_dec, (state_q == ST_MOVE) |=> (count_q == $past(count_q) - CW'(1)), "no drop")
	`UPQ_ASSERT(a_emit_loads, emit |=> rsp_valid_q && (state_q == ST_IDLE), "result not presented")

endmodule
